// ===== design/rvc_pkg.sv =====
// Package for the range value count block.
// Holds field widths, action codes, the command type and the back-end state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rvc_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 20;
  localparam int ACTION_BITS    = 2;
  localparam int POS_BITS       = 11;
  localparam int COUNT_BITS     = 11;

  localparam logic [ACTION_BITS-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_QUERY  = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_QUERY,
    OP_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic [POS_BITS-1:0] lo;
    logic [POS_BITS-1:0] hi;
  } cmd_ctrl_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DRAIN
  } back_state_t;

endpackage
`default_nettype wire

// ===== design/range_value_count.sv =====
// Top level of the range value count block: front end, command queue and back end.
// Depends on rvc_pkg, rvc_front, rvc_queue and rvc_back.
//
// The block stores up to DEPTH elements appended one item at a time and answers
// range count queries over them. A query scans its clipped range: the back end
// reads the element RAM through its single read port one position per cycle and
// then compares the last element; an empty range is answered without a scan. A
// two-entry queue lets the front end keep accepting items while the back end
// scans, and a result register holds each count until it is taken. The back
// end starts no command while a count waits to be taken, so a stalled result
// channel fills the queue and then holds off the input.
`timescale 1ns / 1ps
`default_nettype none
module range_value_count
  import rvc_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire logic [ACTION_BITS-1:0] action,
  input  wire logic [VALUE_BITS-1:0]  item_value,
  input  wire logic [POS_BITS-1:0]    range_low,
  input  wire logic [POS_BITS-1:0]    range_high,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output logic      [COUNT_BITS-1:0]  match_count
);

  localparam int QW = $bits(cmd_ctrl_t) + VALUE_BITS;

  cmd_ctrl_t             front_ctrl;
  logic                  push;
  logic                  q_ready;
  logic                  q_valid;
  logic [QW-1:0]         q_data;
  logic                  q_pop;
  cmd_ctrl_t             back_ctrl;
  logic [VALUE_BITS-1:0] back_value;

  rvc_front u_front (
    .item_valid (item_valid),
    .item_ready (item_ready),
    .action     (action),
    .range_low  (range_low),
    .range_high (range_high),
    .q_ready    (q_ready),
    .push       (push),
    .ctrl       (front_ctrl)
  );

  rvc_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({front_ctrl, item_value}),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  assign back_ctrl  = cmd_ctrl_t'(q_data[QW-1:VALUE_BITS]);
  assign back_value = q_data[VALUE_BITS-1:0];

  rvc_back #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (q_valid),
    .cmd_pop      (q_pop),
    .cmd_ctrl     (back_ctrl),
    .cmd_value    (back_value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .match_count  (match_count)
  );

endmodule
`default_nettype wire

// ===== design/rvc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module rvc_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/rvc_front.sv =====
// Front end: accepts input items and classifies them into back-end commands.
// Depends on rvc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rvc_front
  import rvc_pkg::*;
(
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire logic [ACTION_BITS-1:0] action,
  input  wire logic [POS_BITS-1:0]    range_low,
  input  wire logic [POS_BITS-1:0]    range_high,
  input  wire logic                   q_ready,
  output logic                        push,
  output cmd_ctrl_t                   ctrl
);

  logic known;

  assign item_ready = q_ready;

  always_comb begin
    known   = 1'b1;
    ctrl.op = OP_APPEND;
    case (action)
      ACT_APPEND: ctrl.op = OP_APPEND;
      ACT_QUERY:  ctrl.op = OP_QUERY;
      ACT_CLEAR:  ctrl.op = OP_CLEAR;
      default:    known = 1'b0;
    endcase
    // A low bound of zero means the first position.
    ctrl.lo = (range_low == '0) ? POS_BITS'(1) : range_low;
    ctrl.hi = range_high;
  end

  assign push = item_valid && q_ready && known;

endmodule
`default_nettype wire

// ===== design/rvc_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module rvc_queue #(
  parameter int WIDTH = 44
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  ready,
  input  wire logic             pop,
  output logic                  valid,
  output logic      [WIDTH-1:0] data
);

  logic [WIDTH-1:0] entries [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       fill;

  assign ready = (fill != 2'd2);
  assign valid = (fill != 2'd0);
  assign data  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/rvc_back.sv =====
// Back end: carries out append, clear and query commands against the element RAM.
// A query scans the clipped range one element per cycle. Depends on rvc_pkg and rvc_ram.
`timescale 1ns / 1ps
`default_nettype none
module rvc_back
  import rvc_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_pop,
  input  wire cmd_ctrl_t             cmd_ctrl,
  input  wire logic [VALUE_BITS-1:0] cmd_value,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output logic      [COUNT_BITS-1:0] match_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_BITS) ? CW : POS_BITS;

  back_state_t state;
  back_state_t state_next;

  logic [CW-1:0]         fill;
  logic [CW-1:0]         fill_next;
  logic [PW-1:0]         pos;
  logic [PW-1:0]         pos_next;
  logic [PW-1:0]         last;
  logic [PW-1:0]         last_next;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic [VALUE_BITS-1:0] seek;
  logic                  cmp_valid;
  logic                  load_result;
  logic [COUNT_BITS-1:0] result_value;

  logic                  take;
  logic [PW-1:0]         lo_ext;
  logic [PW-1:0]         hi_clip;
  logic                  empty_range;

  logic                  ram_we;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  rvc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill[AW-1:0]),
    .wdata (cmd_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign take = (state == B_IDLE) && cmd_valid && (!result_valid || result_ready);
  assign lo_ext = PW'(cmd_ctrl.lo);
  assign hi_clip = (PW'(cmd_ctrl.hi) > PW'(fill)) ? PW'(fill) : PW'(cmd_ctrl.hi);
  assign empty_range = (lo_ext > hi_clip);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (take && (cmd_ctrl.op == OP_QUERY) && !empty_range) begin
          state_next = B_SCAN;
        end
      end
      B_SCAN: begin
        if (pos == last) begin
          state_next = B_DRAIN;
        end
      end
      B_DRAIN: state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop      = take;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = AW'(pos - PW'(1));
    fill_next    = fill;
    pos_next     = pos;
    last_next    = last;
    load_result  = 1'b0;
    result_value = '0;
    count_next   = count;
    if (cmp_valid && (ram_rdata == seek)) begin
      count_next = count + COUNT_BITS'(1);
    end
    case (state)
      B_IDLE: begin
        if (take) begin
          case (cmd_ctrl.op)
            OP_APPEND: begin
              if (fill < CW'(DEPTH)) begin
                ram_we    = 1'b1;
                fill_next = fill + CW'(1);
              end
            end
            OP_CLEAR: fill_next = '0;
            OP_QUERY: begin
              pos_next   = lo_ext;
              last_next  = hi_clip;
              count_next = '0;
              if (empty_range) begin
                load_result = 1'b1;
              end
            end
            default: fill_next = fill;
          endcase
        end
      end
      B_SCAN: begin
        ram_re   = 1'b1;
        pos_next = pos + PW'(1);
      end
      B_DRAIN: begin
        load_result  = 1'b1;
        result_value = count_next;
      end
      default: ram_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    pos   <= pos_next;
    last  <= last_next;
    count <= count_next;
    if (take) begin
      seek <= cmd_value;
    end
    if (load_result) begin
      match_count <= result_value;
    end
    if (rst) begin
      state        <= B_IDLE;
      fill         <= '0;
      cmp_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      cmp_valid <= (state == B_SCAN);
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
